@@ rtl/bsfr_pkg.sv @@
`default_nettype none

package bsfr_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_START_DELIM = 2'd0;
    localparam logic [1:0] REG_END_DELIM   = 2'd1;
    localparam logic [1:0] REG_MAX_SIZE    = 2'd2;

    localparam logic [7:0]  RST_START_DELIM = 8'hFF;
    localparam logic [7:0]  RST_END_DELIM   = 8'hFF;
    localparam logic [15:0] RST_MAX_SIZE    = 16'd16384;

    localparam logic [7:0] ESC_BYTE = 8'hFD;
    localparam logic [7:0] ALT_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        logic [15:0] frame_bytes;
        logic        closed_by_limit;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/byte_stuffed_frame_receiver_top.sv @@
// An item is registered on acceptance into the input register, and its result is then
// registered in the result register, which drives the outputs.
// Throughput: one item per cycle; the input register and the result register form a
// two-stage pipeline that stalls only while a result waits on out_ready.
// Reset (rst_n, asynchronous, active low): hunting for the start delimiter, pipeline
// empty, registers at start 0xFF, end 0xFF, max frame size 16384.
`default_nettype none

module byte_stuffed_frame_receiver_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bsfr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bsfr_pkg::DATA_W-1:0]  pwdata,
    output      logic [bsfr_pkg::DATA_W-1:0]  prdata,
    output      logic                         pready,

    input  wire logic                         in_valid,
    output      logic                         in_ready,
    input  wire logic [7:0]                   rx_byte,

    output      logic                         out_valid,
    input  wire logic                         out_ready,
    output      logic [7:0]                   payload_byte,
    output      logic                         payload_valid,
    output      logic                         frame_done,
    output      logic [15:0]                  frame_bytes,
    output      logic                         closed_by_limit
);

    logic [7:0]  start_delim_reg;
    logic [7:0]  end_delim_reg;
    logic [15:0] max_size_reg;
    logic        cfg_write;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        in_frame_reg;
    logic        in_frame_next;
    logic        esc_reg;
    logic        esc_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    bsfr_pkg::result_t   res_reg;
    bsfr_pkg::result_t   res_next;
    logic                emit;

    logic        advance;
    logic [15:0] limit;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg <= bsfr_pkg::RST_START_DELIM;
            end_delim_reg   <= bsfr_pkg::RST_END_DELIM;
            max_size_reg    <= bsfr_pkg::RST_MAX_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                bsfr_pkg::REG_START_DELIM: start_delim_reg <= pwdata[7:0];
                bsfr_pkg::REG_END_DELIM:   end_delim_reg   <= pwdata[7:0];
                bsfr_pkg::REG_MAX_SIZE:    max_size_reg    <= pwdata[15:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            bsfr_pkg::REG_START_DELIM: prdata = {24'd0, start_delim_reg};
            bsfr_pkg::REG_END_DELIM:   prdata = {24'd0, end_delim_reg};
            bsfr_pkg::REG_MAX_SIZE:    prdata = {16'd0, max_size_reg};
            default:                   prdata = '0;
        endcase
    end

    // pipeline control
    assign advance  = ~out_valid_reg | out_ready;
    assign in_ready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // deframing
    assign limit = (max_size_reg == 16'd0) ? 16'd0 : max_size_reg - 16'd1;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        res_next      = '0;

        if (!in_frame_reg)
        begin
            if (in_byte_reg == start_delim_reg)
            begin
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                count_next    = 16'd0;
            end
        end
        else if (esc_reg)
        begin
            esc_next = 1'b0;
            if ((in_byte_reg == bsfr_pkg::ESC_BYTE || in_byte_reg == bsfr_pkg::ALT_BYTE)
                && count_reg < max_size_reg)
            begin
                count_next             = count_reg + 16'd1;
                emit                   = 1'b1;
                res_next.payload_byte  = in_byte_reg;
                res_next.payload_valid = 1'b1;
            end
        end
        else if (in_byte_reg == bsfr_pkg::ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else if (in_byte_reg == end_delim_reg || count_reg >= limit)
        begin
            emit                     = 1'b1;
            res_next.frame_done      = 1'b1;
            res_next.frame_bytes     = count_reg;
            res_next.closed_by_limit = (in_byte_reg != end_delim_reg);
            in_frame_next            = 1'b0;
            count_next               = 16'd0;
        end
        else
        begin
            count_next             = count_reg + 16'd1;
            emit                   = 1'b1;
            res_next.payload_byte  = in_byte_reg;
            res_next.payload_valid = 1'b1;
        end
    end

    assign out_valid_next = in_valid_reg & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            count_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= out_valid_next;
            if (in_valid_reg)
            begin
                in_frame_reg <= in_frame_next;
                esc_reg      <= esc_next;
                count_reg    <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && out_valid_next)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign payload_byte    = res_reg.payload_byte;
    assign payload_valid   = res_reg.payload_valid;
    assign frame_done      = res_reg.frame_done;
    assign frame_bytes     = res_reg.frame_bytes;
    assign closed_by_limit = res_reg.closed_by_limit;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int PIPE_FLUSH  = 4;
    localparam int PHASE_BYTES = 200;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_SPARSE, RDY_DENSE, RDY_BURSTY} ready_mode_t;

    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [bsfr_pkg::ADDR_W-1:0]   paddr           = '0;
    logic [bsfr_pkg::DATA_W-1:0]   pwdata          = '0;
    logic [bsfr_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid        = 1'b0;
    logic                          in_ready;
    logic [7:0]                    rx_byte         = 8'h00;
    logic                          out_valid;
    logic                          out_ready       = 1'b0;
    logic [7:0]                    payload_byte;
    logic                          payload_valid;
    logic                          frame_done;
    logic [15:0]                   frame_bytes;
    logic                          closed_by_limit;

    // deframer shadow: configuration and state
    logic [7:0]          start_code      = bsfr_pkg::RST_START_DELIM;
    logic [7:0]          end_code        = bsfr_pkg::RST_END_DELIM;
    logic [15:0]         size_limit      = bsfr_pkg::RST_MAX_SIZE;
    logic                rcv_open        = 1'b0;
    logic                rcv_escaped     = 1'b0;
    logic [15:0]         rcv_count       = 16'd0;

    logic [7:0]          link_bytes[$];
    bsfr_pkg::result_t   pending_results[$];
    int                  unsent          = 0;
    int                  err_count       = 0;
    int                  quiet_cycles    = 0;
    logic                sender_hold     = 1'b0;
    int                  burst_left      = 0;
    int                  gap_left        = 0;
    logic [31:0]         ready_tick      = '0;
    ready_mode_t         ready_mode      = RDY_ALWAYS;

    byte_stuffed_frame_receiver_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .payload_byte    (payload_byte),
        .payload_valid   (payload_valid),
        .frame_done      (frame_done),
        .frame_bytes     (frame_bytes),
        .closed_by_limit (closed_by_limit)
    );

    always #5 clk = ~clk;

    task automatic flag_error(input string what, input int want, input int got);
        err_count++;
        $display("ERROR %0s: want %0h got %0h", what, want, got);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        bsfr_pkg::result_t r;
        logic [15:0]       lim;
        lim = (size_limit != 16'd0) ? size_limit - 16'd1 : 16'd0;
        r = '0;
        if (!rcv_open)
        begin
            if (b == start_code)
            begin
                rcv_open    = 1'b1;
                rcv_escaped = 1'b0;
                rcv_count   = 16'd0;
            end
        end
        else if (rcv_escaped)
        begin
            rcv_escaped = 1'b0;
            if ((b == bsfr_pkg::ESC_BYTE || b == bsfr_pkg::ALT_BYTE) && rcv_count < size_limit)
            begin
                rcv_count       = rcv_count + 16'd1;
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                pending_results.push_back(r);
            end
        end
        else if (b == bsfr_pkg::ESC_BYTE)
            rcv_escaped = 1'b1;
        else if (b == end_code || rcv_count >= lim)
        begin
            r.frame_done      = 1'b1;
            r.frame_bytes     = rcv_count;
            r.closed_by_limit = (b != end_code);
            pending_results.push_back(r);
            rcv_open  = 1'b0;
            rcv_count = 16'd0;
        end
        else
        begin
            rcv_count       = rcv_count + 16'd1;
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            pending_results.push_back(r);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        unsent++;
    endtask

    task automatic queue_frame(input bit broken);
        int         n_noise;
        int         n_pay;
        int         cut;
        int         k;
        logic [7:0] b;
        n_noise = $urandom_range(0, 2);
        n_pay   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
        cut     = broken ? $urandom_range(0, n_pay) : -1;
        for (k = 0; k < n_noise; k++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b != start_code || broken)
                push_byte(b);
        end
        push_byte(start_code);
        for (k = 0; k < n_pay; k++)
        begin
            if (k == cut)
            begin
                // escape with a bad partner: both dropped
                b = 8'($urandom_range(0, 253));
                if (b == bsfr_pkg::ESC_BYTE)
                    b = 8'hFE;
                push_byte(bsfr_pkg::ESC_BYTE);
                push_byte(b);
            end
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0)
                b = $urandom_range(0, 1) ? bsfr_pkg::ESC_BYTE : bsfr_pkg::ALT_BYTE;
            if (b == end_code && b != bsfr_pkg::ESC_BYTE && b != bsfr_pkg::ALT_BYTE)
                b = b ^ 8'h01;
            if (b == bsfr_pkg::ESC_BYTE || b == bsfr_pkg::ALT_BYTE)
                push_byte(bsfr_pkg::ESC_BYTE);
            push_byte(b);
        end
        if (!broken || $urandom_range(0, 1) == 0)
            push_byte(end_code);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [bsfr_pkg::DATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bsfr_pkg::REG_START_DELIM: start_code = val[7:0];
            bsfr_pkg::REG_END_DELIM:   end_code   = val[7:0];
            bsfr_pkg::REG_MAX_SIZE:    size_limit = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        @(posedge clk);
        while (unsent != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    // sender: bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rx_byte    <= 8'h00;
            burst_left = $urandom_range(0, 40);
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                unsent--;
                deframe_byte(rx_byte);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (sender_hold || link_bytes.size() == 0)
                    in_valid <= 1'b0;
                else
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= link_bytes.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: stall pattern is redrawn whenever ready_tick[5:0] is zero
    always @(posedge clk)
    begin
        bsfr_pkg::result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    flag_error("item with nothing expected", 0, 1);
                else
                begin
                    want = pending_results.pop_front();
                    if (payload_byte !== want.payload_byte)
                        flag_error("payload_byte", int'(want.payload_byte),
                                   int'(payload_byte));
                    if (payload_valid !== want.payload_valid)
                        flag_error("payload_valid", int'(want.payload_valid),
                                   int'(payload_valid));
                    if (frame_done !== want.frame_done)
                        flag_error("frame_done", int'(want.frame_done), int'(frame_done));
                    if (frame_bytes !== want.frame_bytes)
                        flag_error("frame_bytes", int'(want.frame_bytes), int'(frame_bytes));
                    if (closed_by_limit !== want.closed_by_limit)
                        flag_error("closed_by_limit", int'(want.closed_by_limit),
                                   int'(closed_by_limit));
                end
            end
            ready_tick <= ready_tick + 1;
            if (ready_tick[5:0] == 6'd0)
                ready_mode <= ready_mode_t'($urandom_range(0, 3));
            case (ready_mode)
                RDY_ALWAYS: out_ready <= 1'b1;
                RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                RDY_DENSE:  out_ready <= ($urandom_range(0, 3) != 0);
                default:    out_ready <= ready_tick[2];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          ph;
        logic [7:0]  s_val;
        logic [7:0]  e_val;
        logic [15:0] m_val;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: hunting, escapes, bad escape, close on delimiter
        @(posedge clk);
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00); push_byte(8'h80);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ESC_BYTE);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ALT_BYTE);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(8'h12); push_byte(8'hFF);
        drain();

        // smallest legal size: start code as data, limit close, saturation,
        // end code arriving at the limit
        cfg_write(bsfr_pkg::REG_START_DELIM, 32'h00);
        cfg_write(bsfr_pkg::REG_END_DELIM, 32'h33);
        cfg_write(bsfr_pkg::REG_MAX_SIZE, 32'd2);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h55);
        push_byte(8'h00); push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ALT_BYTE);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ESC_BYTE);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ALT_BYTE);
        push_byte(8'h33);
        drain();

        // end code equal to the escape, sizes zero and one
        cfg_write(bsfr_pkg::REG_START_DELIM, 32'hFD);
        cfg_write(bsfr_pkg::REG_END_DELIM, 32'hFD);
        cfg_write(bsfr_pkg::REG_MAX_SIZE, 32'd0);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(bsfr_pkg::ESC_BYTE);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(8'h01);
        drain();
        cfg_write(bsfr_pkg::REG_MAX_SIZE, 32'd1);
        push_byte(bsfr_pkg::ESC_BYTE); push_byte(8'h42);
        drain();

        for (ph = 0; ph < 6; ph++)
        begin
            s_val = 8'($urandom_range(0, 255));
            e_val = 8'($urandom_range(0, 255));
            m_val = 16'($urandom_range(2, 24));
            case (ph)
                0: e_val = s_val;
                1: begin s_val = 8'h00; e_val = 8'hFF; m_val = 16'hFFFF; end
                2: m_val = 16'd2;
                4: begin s_val = 8'hFF; e_val = 8'h00; m_val = 16'($urandom_range(3, 8)); end
                5: m_val = bsfr_pkg::RST_MAX_SIZE;
                default: ;
            endcase
            cfg_write(bsfr_pkg::REG_START_DELIM, {24'd0, s_val});
            cfg_write(bsfr_pkg::REG_END_DELIM, {24'd0, e_val});
            cfg_write(bsfr_pkg::REG_MAX_SIZE, {16'd0, m_val});
            while (unsent < PHASE_BYTES)
                queue_frame($urandom_range(0, 9) == 0);
            if (ph == 3)
            begin
                while (unsent > PHASE_BYTES / 2)
                    @(posedge clk);
                sender_hold <= 1'b1;
                @(posedge clk);
                @(posedge clk);
                while (in_valid || pending_results.size() != 0)
                    @(posedge clk);
                sender_hold <= 1'b0;
            end
            drain();
        end

        repeat (PIPE_FLUSH) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/bsfr_pkg.sv
rtl/byte_stuffed_frame_receiver_top.sv
verif/tb_top.sv
